// ----- design/wpa_pkg.sv -----
// ----------------------------------------------------------------------------
// wpa_pkg: shared types and constants of the water priority arbiter
// Payload structs of both channels, request, status and valve codes, and the
// moisture threshold table used by the level quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package wpa_pkg;

  // Request codes
  localparam logic [1:0] REQ_REPORT  = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_READING = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_VALVE  = 1'b1;

  // Status codes
  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_ADDED    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_REMOVED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_READING  = 3'd5;

  // Valve states
  localparam logic [1:0] VALVE_CLOSED  = 2'd0;
  localparam logic [1:0] VALVE_OPEN    = 2'd1;
  localparam logic [1:0] VALVE_INVALID = 2'd2;

  localparam logic [2:0] LEVEL_INVALID = 3'd7;

  // Configuration port
  localparam int unsigned CFG_IW = 1;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CFG_IW-1:0] CFG_REQ_LEVEL = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_OWN_ADDR  = 1'b1;

  // Quantizer: percent thresholds stepped through by one shared multiplier
  localparam int unsigned Q_STEPS = 12;
  localparam int unsigned QW      = 4;
  localparam int unsigned PW      = 23;
  localparam logic [6:0]  Q_SCALE = 7'd100;

  // Positions of the thresholds in the table
  localparam logic [QW-1:0] QT_5   = 4'd0;
  localparam logic [QW-1:0] QT_10  = 4'd1;
  localparam logic [QW-1:0] QT_20  = 4'd2;
  localparam logic [QW-1:0] QT_25  = 4'd3;
  localparam logic [QW-1:0] QT_40  = 4'd4;
  localparam logic [QW-1:0] QT_45  = 4'd5;
  localparam logic [QW-1:0] QT_60  = 4'd6;
  localparam logic [QW-1:0] QT_65  = 4'd7;
  localparam logic [QW-1:0] QT_80  = 4'd8;
  localparam logic [QW-1:0] QT_85  = 4'd9;
  localparam logic [QW-1:0] QT_95  = 4'd10;
  localparam logic [QW-1:0] QT_100 = 4'd11;

  function automatic logic [6:0] q_thresh(input logic [QW-1:0] step);
    logic [6:0] k;
    case (step)
      QT_5:    k = 7'd5;
      QT_10:   k = 7'd10;
      QT_20:   k = 7'd20;
      QT_25:   k = 7'd25;
      QT_40:   k = 7'd40;
      QT_45:   k = 7'd45;
      QT_60:   k = 7'd60;
      QT_65:   k = 7'd65;
      QT_80:   k = 7'd80;
      QT_85:   k = 7'd85;
      QT_95:   k = 7'd95;
      default: k = 7'd100;
    endcase
    return k;
  endfunction

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] peer_address;
    logic [2:0]  peer_level;
    logic [7:0]  peer_rank;
    logic [15:0] moisture;
    logic [7:0]  own_rank;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [1:0] valve;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/water_priority_arbiter_core.sv -----
// The status result (out_valid high) follows a lookup walk of the peer memory for
// a report or missed removal, a lookup and an arbitration walk for a removal hit,
// and for an own reading the quantizer, then walks with the old (on a level change)
// and the new priority; cycles with out_ready low delay it further.
// Throughput: one item at a time; in_ready is high only while the sequencer idles.
// Reset (rst_n low, synchronous) empties the table, marks the own level invalid.
// ----------------------------------------------------------------------------
// water_priority_arbiter_core: valve arbitration among peer boxes
// Keeps a table of peers (address, level, rank), quantizes the own moisture
// reading into a level and decides by a serial walk whether this box may open.
// ----------------------------------------------------------------------------
`default_nettype none

module water_priority_arbiter_core #(
  parameter int unsigned PEERS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wpa_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output wpa_pkg::out_item_t               out_data,
  input  wire                              cfg_we,
  input  wire  [wpa_pkg::CFG_IW-1:0]       cfg_idx,
  input  wire  [wpa_pkg::CFG_DW-1:0]       cfg_wdata
);

  import wpa_pkg::*;

  // Entry index width and walk counter width (counter also holds PEERS)
  localparam int unsigned IW = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int unsigned CW = $clog2(PEERS + 1);

  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  level;
    logic [7:0]  rank;
  } entry_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WALK  = 9'b000000010,  // lookup walk: find match and lowest free slot
    S_APPLY = 9'b000000100,  // write or invalidate the entry found
    S_QMUL  = 9'b000001000,  // scale the reading by 100
    S_QCMP  = 9'b000010000,  // compare against one threshold per cycle
    S_QSET  = 9'b000100000,  // pick the new own level
    S_ARB   = 9'b001000000,  // arbitration walk
    S_VALVE = 9'b010000000,  // report a changed valve state
    S_STAT  = 9'b100000000   // final status transfer
  } state_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t          state_r, state_nxt;
  in_item_t        in_q_r, in_q_nxt;
  logic [15:0]     req_lvl_r, req_lvl_nxt;
  logic [31:0]     own_addr_r, own_addr_nxt;
  logic [PEERS-1:0] valid_r, valid_nxt;
  logic [2:0]      own_level_r, own_level_nxt;
  logic [7:0]      own_prio_r, own_prio_nxt;
  logic [1:0]      valve_now_r, valve_now_nxt;

  // Walk state
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pv_r, pv_nxt;           // compare stage holds a read entry
  logic [IW-1:0]   pidx_r, pidx_nxt;
  logic            hit_r, hit_nxt;
  logic [IW-1:0]   hit_idx_r, hit_idx_nxt;
  logic            free_r, free_nxt;
  logic [IW-1:0]   free_idx_r, free_idx_nxt;
  logic            lose_r, lose_nxt;
  logic            pass_r, pass_nxt;       // second arbitration of a reading
  logic [2:0]      st_r, st_nxt;

  // Quantizer state
  logic [QW-1:0]      step_r, step_nxt;
  logic [PW-1:0]      m100_r, m100_nxt;
  logic [Q_STEPS-1:0] lt_r, lt_nxt;
  logic [Q_STEPS-1:0] gt_r, gt_nxt;

  // Result register
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_q_r, out_q_nxt;

  // Peer memory
  entry_t          mem [PEERS];
  entry_t          rd_q_r;
  logic            rd_en;
  logic [IW-1:0]   rd_idx;
  logic            mem_we;
  logic [IW-1:0]   mem_widx;
  entry_t          mem_wdata;

  // --------------------------------------------------------------------------
  // Shared units
  // --------------------------------------------------------------------------
  logic [15:0]   mul_a;
  logic [6:0]    mul_b;
  logic [PW-1:0] prod;
  logic [31:0]   key_addr;
  logic          addr_eq;
  logic          addr_lt;
  logic          peer_lt;
  logic          walking;
  logic          walk_done;
  logic          walk_clr;
  logic          out_free;
  logic [2:0]    q_level;
  logic [1:0]    arb_valve;

  // One multiplier: reading times 100, or required level times a threshold
  always_comb begin
    mul_a = (state_r == S_QMUL) ? in_q_r.moisture : req_lvl_r;
    mul_b = (state_r == S_QMUL) ? Q_SCALE : q_thresh(step_r);
    prod  = {7'd0, mul_a} * {16'd0, mul_b};
  end

  // One comparator on the entry read from memory
  always_comb begin
    key_addr = (state_r == S_WALK) ? in_q_r.peer_address : own_addr_r;
    addr_eq  = (rd_q_r.addr == key_addr);
    addr_lt  = (rd_q_r.addr < key_addr);
    peer_lt  = (rd_q_r.level < own_level_r) ||
               ((rd_q_r.level == own_level_r) &&
                ((rd_q_r.rank < own_prio_r) ||
                 ((rd_q_r.rank == own_prio_r) && addr_lt)));
  end

  // Level from the threshold flags; gap bands and band edges keep the level
  always_comb begin
    if (lt_r[QT_5]) begin
      q_level = 3'd0;
    end else if (gt_r[QT_10] && lt_r[QT_20]) begin
      q_level = 3'd1;
    end else if (gt_r[QT_25] && lt_r[QT_40]) begin
      q_level = 3'd2;
    end else if (gt_r[QT_45] && lt_r[QT_60]) begin
      q_level = 3'd3;
    end else if (gt_r[QT_65] && lt_r[QT_80]) begin
      q_level = 3'd4;
    end else if (gt_r[QT_85] && lt_r[QT_95]) begin
      q_level = 3'd5;
    end else if (!lt_r[QT_100]) begin
      q_level = 3'd6;
    end else begin
      q_level = own_level_r;
    end
  end

  always_comb begin
    if (own_level_r == LEVEL_INVALID) begin
      arb_valve = VALVE_INVALID;
    end else if (lose_r) begin
      arb_valve = VALVE_CLOSED;
    end else begin
      arb_valve = VALVE_OPEN;
    end
  end

  assign walking   = (state_r == S_WALK) || (state_r == S_ARB);
  assign walk_done = (cnt_r == CW'(PEERS)) && !pv_r;
  assign out_free  = !out_valid_r || out_ready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    in_q_nxt      = in_q_r;
    req_lvl_nxt   = req_lvl_r;
    own_addr_nxt  = own_addr_r;
    valid_nxt     = valid_r;
    own_level_nxt = own_level_r;
    own_prio_nxt  = own_prio_r;
    valve_now_nxt = valve_now_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = pv_r;
    pidx_nxt      = pidx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    lose_nxt      = lose_r;
    pass_nxt      = pass_r;
    st_nxt        = st_r;
    step_nxt      = step_r;
    m100_nxt      = m100_r;
    lt_nxt        = lt_r;
    gt_nxt        = gt_r;
    out_valid_nxt = out_valid_r;
    out_q_nxt     = out_q_r;
    rd_en         = 1'b0;
    rd_idx        = cnt_r[IW-1:0];
    mem_we        = 1'b0;
    mem_widx      = hit_idx_r;
    mem_wdata     = '{addr: in_q_r.peer_address, level: in_q_r.peer_level,
                      rank: in_q_r.peer_rank};
    walk_clr      = 1'b0;

    // Drop the held result once it is transferred
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes are to arrive only while idle; the user must keep to this, the block does not enforce it
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_REQ_LEVEL: req_lvl_nxt  = cfg_wdata[15:0];
        CFG_OWN_ADDR:  own_addr_nxt = cfg_wdata;
        default: ;
      endcase
    end

    // Walk: issue one read a cycle, compare the entry read the cycle before
    if (walking) begin
      if (cnt_r != CW'(PEERS)) begin
        rd_en    = 1'b1;
        pv_nxt   = 1'b1;
        pidx_nxt = cnt_r[IW-1:0];
        cnt_nxt  = cnt_r + CW'(1);
      end else begin
        pv_nxt = 1'b0;
      end
      if (pv_r) begin
        if (valid_r[pidx_r]) begin
          if (state_r == S_WALK) begin
            if (!hit_r && addr_eq) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = pidx_r;
            end
          end else if (peer_lt) begin
            lose_nxt = 1'b1;
          end
        end else if (state_r == S_WALK && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = pidx_r;
        end
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_q_nxt = in_data;
          unique case (in_data.req_type) inside
            REQ_REPORT, REQ_REMOVE: begin
              walk_clr  = 1'b1;
              state_nxt = S_WALK;
            end
            REQ_READING: begin
              st_nxt    = ST_READING;
              pass_nxt  = 1'b0;
              state_nxt = S_QMUL;
            end
            default: ;  // unused request: take it and answer nothing
          endcase
        end
      end

      S_WALK: begin
        if (walk_done) begin
          state_nxt = S_APPLY;
        end
      end

      S_APPLY: begin
        if (in_q_r.req_type == REQ_REPORT) begin
          state_nxt = S_STAT;
          if (hit_r) begin
            mem_we   = 1'b1;
            mem_widx = hit_idx_r;
            st_nxt   = ST_UPDATED;
          end else if (free_r) begin
            mem_we               = 1'b1;
            mem_widx             = free_idx_r;
            valid_nxt[free_idx_r] = 1'b1;
            st_nxt               = ST_ADDED;
          end else begin
            st_nxt = ST_FULL;
          end
        end else if (hit_r) begin
          valid_nxt[hit_idx_r] = 1'b0;
          st_nxt               = ST_REMOVED;
          walk_clr             = 1'b1;
          state_nxt            = S_ARB;
        end else begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_STAT;
        end
      end

      S_QMUL: begin
        m100_nxt  = prod;
        step_nxt  = '0;
        state_nxt = S_QCMP;
      end

      S_QCMP: begin
        lt_nxt[step_r] = (m100_r < prod);
        gt_nxt[step_r] = (m100_r > prod);
        step_nxt       = step_r + QW'(1);
        if (step_r == QW'(Q_STEPS - 1)) begin
          state_nxt = S_QSET;
        end
      end

      S_QSET: begin
        own_level_nxt = q_level;
        walk_clr      = 1'b1;
        state_nxt     = S_ARB;
        // Unchanged level: skip the pass with the old priority
        if (q_level == own_level_r) begin
          own_prio_nxt = in_q_r.own_rank;
          pass_nxt     = 1'b1;
        end
      end

      S_ARB: begin
        if (walk_done) begin
          state_nxt = S_VALVE;
        end
      end

      S_VALVE: begin
        if (arb_valve == valve_now_r || out_free) begin
          if (arb_valve != valve_now_r) begin
            valve_now_nxt = arb_valve;
            out_valid_nxt = 1'b1;
            out_q_nxt     = '{kind: KIND_VALVE, status: ST_UPDATED,
                              valve: arb_valve, last: 1'b0};
          end
          if (in_q_r.req_type == REQ_READING && !pass_r) begin
            own_prio_nxt = in_q_r.own_rank;
            pass_nxt     = 1'b1;
            walk_clr     = 1'b1;
            state_nxt    = S_ARB;
          end else begin
            state_nxt = S_STAT;
          end
        end
      end

      S_STAT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_q_nxt     = '{kind: KIND_STATUS, status: st_r,
                            valve: valve_now_r, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Start a fresh walk
    if (walk_clr) begin
      cnt_nxt  = '0;
      pv_nxt   = 1'b0;
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
      lose_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_lvl_r   <= '0;
      own_addr_r  <= '0;
      valid_r     <= '0;
      own_level_r <= LEVEL_INVALID;
      own_prio_r  <= '0;
      valve_now_r <= VALVE_CLOSED;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      lose_r      <= 1'b0;
      pass_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_lvl_r   <= req_lvl_nxt;
      own_addr_r  <= own_addr_nxt;
      valid_r     <= valid_nxt;
      own_level_r <= own_level_nxt;
      own_prio_r  <= own_prio_nxt;
      valve_now_r <= valve_now_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      lose_r      <= lose_nxt;
      pass_r      <= pass_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    in_q_r     <= in_q_nxt;
    pidx_r     <= pidx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    st_r       <= st_nxt;
    m100_r     <= m100_nxt;
    lt_r       <= lt_nxt;
    gt_r       <= gt_nxt;
    out_q_r    <= out_q_nxt;
  end

  // Peer memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_idx];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

`ifndef SYNTHESIS
  // A real request keeps the sequencer busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.req_type != REQ_NONE) |=> !in_ready)
    else $error("sequencer idle right after taking a request");

  // The compare stage only holds data during a walk
  a_walk_stage: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == S_WALK || state_r == S_ARB))
    else $error("walk compare stage live outside a walk");

  // A valve message is always followed by the status of the same item
  a_valve_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_VALVE) |-> !out_data.last)
    else $error("valve message marked as final result");

  // Seen while idle, an invalid valve state only while the own level is invalid
  a_valve_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && valve_now_r == VALVE_INVALID) |->
      (own_level_r == LEVEL_INVALID))
    else $error("valve invalid with a valid own level");
`endif

endmodule

`default_nettype wire

// ----- tb/water_priority_arbiter_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// water_priority_arbiter_core_tb: self-checking bench for the valve arbiter
// Sends peer reports, peer removals and own moisture readings through the
// valid/ready input, predicts every status reply and valve message inside the
// bench, and checks each output transfer against the oldest pending prediction.
// A short directed table comes first, then random phases under several
// register settings, with random idling on both channels outside one calm phase.
// ----------------------------------------------------------------------------

module water_priority_arbiter_core_tb;
  import wpa_pkg::*;

  localparam int unsigned PEERS  = 16;
  // Slowest item is an own reading; leave margin.
  localparam int unsigned SETTLE = 2 * PEERS + 40;
  localparam int unsigned N_DIR  = 25;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we    = 1'b0;
  logic [CFG_IW-1:0]  cfg_idx   = '0;
  logic [CFG_DW-1:0]  cfg_wdata = '0;

  // Bench copy of the peer table, own state and registers
  logic        peer_live [PEERS];
  logic [31:0] peer_addr [PEERS];
  logic [2:0]  peer_lvl  [PEERS];
  logic [7:0]  peer_rank [PEERS];
  logic [2:0]  own_lvl;
  logic [7:0]  own_prio;
  logic [1:0]  valve_st;
  logic [15:0] req_lvl;
  logic [31:0] own_addr;

  // Results still owed by the block, oldest first, and those of the last item
  out_item_t   reply_q [$];
  out_item_t   fresh_q [$];

  // Directed table: typed rows carry the one status reply they must give
  in_item_t    dir_item  [N_DIR];
  logic        dir_typed [N_DIR];
  out_item_t   dir_res   [N_DIR];
  int          n_dir = 0;

  bit          calm = 1'b0;  // suppress idling on both channels
  int unsigned fail_cnt = 0;

  water_priority_arbiter_core #(
    .PEERS(PEERS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic out_item_t reply(logic kind, logic [2:0] st, logic [1:0] vl,
                                      logic lst);
    out_item_t r;
    r.kind   = kind;
    r.status = st;
    r.valve  = vl;
    r.last   = lst;
    return r;
  endfunction

  // Own box loses to any live peer with a smaller (level, rank, address).
  function automatic logic [1:0] arbitrate_valve();
    if (own_lvl == LEVEL_INVALID) return VALVE_INVALID;
    for (int i = 0; i < PEERS; i++) begin
      if (peer_live[i] && (peer_lvl[i] < own_lvl ||
          (peer_lvl[i] == own_lvl && (peer_rank[i] < own_prio ||
          (peer_rank[i] == own_prio && peer_addr[i] < own_addr)))))
        return VALVE_CLOSED;
    end
    return VALVE_OPEN;
  endfunction

  // Re-arbitrate; emit a valve message only on a change of outcome.
  function automatic void post_valve();
    logic [1:0] v;
    v = arbitrate_valve();
    if (v != valve_st) begin
      valve_st = v;
      // status field reads zero in a valve message
      fresh_q.push_back(reply(KIND_VALVE, ST_UPDATED, v, 1'b0));
    end
  endfunction

  // Open interval test: r*lo < m100 < r*hi, band edges excluded.
  function automatic bit in_band(logic [39:0] m100, logic [39:0] r,
                                 int unsigned lo, int unsigned hi);
    return (m100 > r * lo) && (m100 < r * hi);
  endfunction

  // Map a reading to a level; gap bands and band edges keep the old level.
  function automatic logic [2:0] quantize_level(logic [15:0] m);
    logic [39:0] m100;
    logic [39:0] r;
    m100 = 40'(m) * 40'd100;
    r    = 40'(req_lvl);
    if (m100 < r * 5)             return 3'd0;
    if (in_band(m100, r, 10, 20)) return 3'd1;
    if (in_band(m100, r, 25, 40)) return 3'd2;
    if (in_band(m100, r, 45, 60)) return 3'd3;
    if (in_band(m100, r, 65, 80)) return 3'd4;
    if (in_band(m100, r, 85, 95)) return 3'd5;
    if (m100 >= r * 100)          return 3'd6;
    return own_lvl;
  endfunction

  // Advance the bench state by one accepted item; leave its results in fresh_q.
  function automatic void apply_request(in_item_t it);
    int         hit;
    int         spare;
    logic [2:0] prev;
    hit   = -1;
    spare = -1;
    fresh_q.delete();
    if (it.req_type == REQ_NONE) return;
    for (int i = 0; i < PEERS; i++) begin
      if (peer_live[i]) begin
        if (hit < 0 && peer_addr[i] == it.peer_address) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    case (it.req_type)
      REQ_REPORT: begin
        // Update in place, else take the lowest free slot, else report full.
        if (hit >= 0) begin
          peer_lvl[hit]  = it.peer_level;
          peer_rank[hit] = it.peer_rank;
          fresh_q.push_back(reply(KIND_STATUS, ST_UPDATED, valve_st, 1'b1));
        end else if (spare >= 0) begin
          peer_live[spare] = 1'b1;
          peer_addr[spare] = it.peer_address;
          peer_lvl[spare]  = it.peer_level;
          peer_rank[spare] = it.peer_rank;
          fresh_q.push_back(reply(KIND_STATUS, ST_ADDED, valve_st, 1'b1));
        end else begin
          fresh_q.push_back(reply(KIND_STATUS, ST_FULL, valve_st, 1'b1));
        end
      end
      REQ_REMOVE: begin
        if (hit >= 0) begin
          peer_live[hit] = 1'b0;
          post_valve();
          fresh_q.push_back(reply(KIND_STATUS, ST_REMOVED, valve_st, 1'b1));
        end else begin
          fresh_q.push_back(reply(KIND_STATUS, ST_NOTFOUND, valve_st, 1'b1));
        end
      end
      default: begin
        // Own reading: arbitrate with the old priority on a level change,
        // then again once the new priority is in place.
        prev    = own_lvl;
        own_lvl = quantize_level(it.moisture);
        if (own_lvl != prev) post_valve();
        own_prio = it.own_rank;
        post_valve();
        fresh_q.push_back(reply(KIND_STATUS, ST_READING, valve_st, 1'b1));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------
  // Small address pool, so reports and removals hit and the table fills up.
  // Its first entries sit right around the own address to exercise ties.
  function automatic logic [31:0] pool_addr();
    int unsigned k;
    k = $urandom_range(21);
    if (k < 3) return own_addr + 32'(k) - 32'd1;
    return 32'(k) * 32'h0DEF_1235;
  endfunction

  function automatic in_item_t rand_request();
    in_item_t    it;
    int unsigned sel;
    int unsigned pct;
    int          m;
    int          live [PEERS];
    int          n_live;
    // Start from fully random fields so every bit toggles, then shape.
    it.req_type     = REQ_NONE;
    it.peer_address = $urandom();
    it.peer_level   = 3'($urandom_range(7));
    it.peer_rank    = 8'($urandom_range(255));
    it.moisture     = 16'($urandom_range(65535));
    it.own_rank     = 8'($urandom_range(255));
    n_live = 0;
    for (int i = 0; i < PEERS; i++) begin
      if (peer_live[i]) begin
        live[n_live] = i;
        n_live++;
      end
    end
    sel = $urandom_range(99);
    if (sel < 6) begin
      it.req_type = REQ_NONE;
    end else if (sel < 42) begin
      it.req_type = REQ_REPORT;
      if ($urandom_range(9) < 8) it.peer_address = pool_addr();
      // Crowd the own level and priority so ties reach the address compare.
      if (own_lvl != LEVEL_INVALID && $urandom_range(1) == 1) it.peer_level = own_lvl;
      if ($urandom_range(2) == 0) it.peer_rank = own_prio;
    end else if (sel < 62) begin
      it.req_type = REQ_REMOVE;
      if (n_live > 0 && $urandom_range(9) < 7)
        it.peer_address = peer_addr[live[$urandom_range(n_live - 1)]];
      else if ($urandom_range(1) == 1)
        it.peer_address = pool_addr();
    end else begin
      it.req_type = REQ_READING;
      // Mostly land within a couple of units of a band threshold.
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(11))
          0:       pct = 5;
          1:       pct = 10;
          2:       pct = 20;
          3:       pct = 25;
          4:       pct = 40;
          5:       pct = 45;
          6:       pct = 60;
          7:       pct = 65;
          8:       pct = 80;
          9:       pct = 85;
          10:      pct = 95;
          default: pct = 100;
        endcase
        m = int'(req_lvl) * int'(pct) / 100 + int'($urandom_range(4)) - 2;
        if (m < 0) m = 0;
        if (m > 65535) m = 65535;
        it.moisture = 16'(m);
      end
      case ($urandom_range(3))
        0:       it.own_rank = own_prio;
        1:       it.own_rank = 8'h00;
        2:       it.own_rank = 8'hFF;
        default: ;
      endcase
    end
    return it;
  endfunction

  function automatic void add_row(int typed, logic [2:0] st, logic [1:0] vl,
                                  logic [1:0] rq, logic [31:0] addr, logic [2:0] lvl,
                                  logic [7:0] rank, logic [15:0] moist, logic [7:0] orank);
    dir_item[n_dir]  = {rq, addr, lvl, rank, moist, orank};
    dir_typed[n_dir] = (typed != 0);
    dir_res[n_dir]   = reply(KIND_STATUS, st, vl, 1'b1);
    n_dir++;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Present one item and hold it until the transfer; then log what it owes.
  task automatic send_item(in_item_t it, logic typed, out_item_t typed_res);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    apply_request(it);
    if (typed) begin
      reply_q.push_back(typed_res);
    end else begin
      foreach (fresh_q[k]) reply_q.push_back(fresh_q[k]);
    end
  endtask

  // Drain: wait for every owed result, then let an ignored item finish too.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both registers back to back; only while the block is idle.
  task automatic set_config(logic [15:0] lvl, logic [31:0] addr);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_REQ_LEVEL;
    cfg_wdata <= {16'h0000, lvl};
    @(posedge clk);
    cfg_idx   <= CFG_OWN_ADDR;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    req_lvl  = lvl;
    own_addr = addr;
  endtask

  // Ignored items do not count toward the phase length.
  task automatic run_phase(int unsigned n_items);
    in_item_t    it;
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      it = rand_request();
      send_item(it, 1'b0, '0);
      if (it.req_type != REQ_NONE) sent++;
    end
  endtask

  // Receiver: stall at random, about 9 times in a hundred, unless the calm stretch is on.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 9);
  end

  // --------------------------------------------------------------------------
  // Checker: compare every output transfer with the oldest pending result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_out
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: result with none pending: kind=%0d status=%0d valve=%0d last=%0d",
                   $time, out_data.kind, out_data.status, out_data.valve, out_data.last);
      end else begin
        want = reply_q.pop_front();
        if (out_data.kind !== want.kind || out_data.status !== want.status ||
            out_data.valve !== want.valve || out_data.last !== want.last) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: expected kind=%0d st=%0d valve=%0d last=%0d, got %0d %0d %0d %0d",
                     $time, want.kind, want.status, want.valve, want.last,
                     out_data.kind, out_data.status, out_data.valve, out_data.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stim
    // Bench state matches the block right after reset.
    for (int i = 0; i < PEERS; i++) begin
      peer_live[i] = 1'b0;
      peer_addr[i] = '0;
      peer_lvl[i]  = '0;
      peer_rank[i] = '0;
    end
    own_lvl  = LEVEL_INVALID;
    own_prio = '0;
    valve_st = VALVE_CLOSED;
    req_lvl  = '0;
    own_addr = '0;

    // Directed table, run with required level 1000 and own address 0x80000000.
    // Fresh table: add, add a peer at level 7, update, miss on removal.
    add_row(1, ST_ADDED,    VALVE_CLOSED, REQ_REPORT,  32'h0000_0000, 3'd0, 8'h00, 16'h0000, 8'h00);
    add_row(1, ST_ADDED,    VALVE_CLOSED, REQ_REPORT,  32'hFFFF_FFFF, 3'd7, 8'hFF, 16'h0000, 8'h00);
    add_row(1, ST_UPDATED,  VALVE_CLOSED, REQ_REPORT,  32'h0000_0000, 3'd6, 8'hFF, 16'hFFFF, 8'hFF);
    add_row(1, ST_NOTFOUND, VALVE_CLOSED, REQ_REMOVE,  32'h1234_5678, 3'd0, 8'h00, 16'h0000, 8'h00);
    // Unused request type with every bit set: no result at all.
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_NONE,    32'hFFFF_FFFF, 3'd7, 8'hFF, 16'hFFFF, 8'hFF);
    // Removal hit while the own level is still invalid.
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_REMOVE,  32'h0000_0000, 3'd0, 8'h00, 16'h0000, 8'h00);
    // Driest and wettest readings, rank extremes.
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'h0000, 8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'hFFFF, 8'hFF);
    // Reports never re-arbitrate: valve stays open.
    add_row(1, ST_ADDED,    VALVE_OPEN,   REQ_REPORT,  32'h0000_0005, 3'd6, 8'hFF, 16'h0000, 8'h00);
    // Same level and rank as that peer: lower peer address closes the valve.
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'hFFFF, 8'hFF);
    // Walk the bands: edges and gaps hold, interiors move.
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd50,   8'hFF);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd49,   8'hFF);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd100,  8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd150,  8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd250,  8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd300,  8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd500,  8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd700,  8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd900,  8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd950,  8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd999,  8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd1000, 8'h00);
    // Peer carrying the own address: a full tie leaves the own box winning.
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_REPORT,  32'h8000_0000, 3'd6, 8'h00, 16'h0000, 8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_READING, 32'h0000_0000, 3'd0, 8'h00, 16'd1000, 8'h00);
    add_row(0, ST_UPDATED,  VALVE_CLOSED, REQ_REMOVE,  32'h8000_0000, 3'd0, 8'h00, 16'h0000, 8'h00);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(16'd1000, 32'h8000_0000);
    for (int i = 0; i < N_DIR; i++) send_item(dir_item[i], dir_typed[i], dir_res[i]);

    // Random phases; drain before every register change.
    quiesce();
    set_config(16'($urandom_range(5000, 200)), $urandom());
    run_phase(90);

    // Zero scale: every reading lands on the top level. No idling here.
    quiesce();
    calm = 1'b1;
    set_config(16'd0, 32'h0000_0000);
    run_phase(90);

    quiesce();
    calm = 1'b0;
    set_config(16'hFFFF, 32'hFFFF_FFFF);
    run_phase(90);

    quiesce();
    set_config(16'($urandom_range(65535, 1)), $urandom());
    run_phase(90);

    quiesce();
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
design/wpa_pkg.sv
design/water_priority_arbiter_core.sv
tb/water_priority_arbiter_core_tb.sv
